// ===== hw/rtl/plu_pkg.sv =====
`timescale 1ns / 1ps

package plu_pkg;

    // Field widths
    localparam int DT_W      = 16;
    localparam int COORD_W   = 32;
    localparam int LIFE_W    = 24;
    localparam int SCALE_W   = 16;
    localparam int CHAN_W    = 8;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Stream payload widths
    localparam int S_TDATA_W = 328;
    localparam int M_TDATA_W = 144;

    // Interpolation lanes: scale, red, green, blue, opacity
    localparam int LANES   = 5;
    localparam int LERP_W  = SCALE_W + 1;
    localparam int LN_SCALE = 0;
    localparam int LN_RED   = 1;
    localparam int LN_GREEN = 2;
    localparam int LN_BLUE  = 3;
    localparam int LN_ALPHA = 4;

    // Item kinds
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_SPAWN = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INIT_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_SCALE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_INIT_COLOR = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_COLOR = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_INIT_ALPHA = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_FINAL_ALPHA = CFG_IDX_W'(5);

    // Register reset values
    localparam logic [SCALE_W-1:0]  RST_INIT_SCALE  = 16'h0100;
    localparam logic [SCALE_W-1:0]  RST_FINAL_SCALE = 16'h0100;
    localparam logic [3*CHAN_W-1:0] RST_INIT_COLOR  = 24'hFFFFFF;
    localparam logic [3*CHAN_W-1:0] RST_FINAL_COLOR = 24'hFFFFFF;
    localparam logic [CHAN_W-1:0]   RST_INIT_ALPHA  = 8'hFF;
    localparam logic [CHAN_W-1:0]   RST_FINAL_ALPHA = 8'h00;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [LIFE_W-1:0]         t_life;

endpackage

// ===== hw/rtl/particle_lifetime_update.sv =====
`timescale 1ns / 1ps

// Single-particle lifetime update with linear fade of scale, color and opacity.
// Input stream: s_axis_tuser selects tick (0) or spawn (1); a spawn loads the
// life span, position and velocity, a tick ages the particle by delta_time and,
// while it stays alive, moves it one Euler step under the given force.
// Output stream: one result per input transfer, alive flag in m_axis_tuser,
// position, scale, RGB and opacity in m_axis_tdata; all zero when dead.
// Config port: i_cfg_we/i_cfg_idx/i_cfg_data write the fade endpoints; write
// only while no item is in flight.
// Flow: one item at a time; the input stays closed from a transfer until its
// result moves into the output register. The work is done by the bit-serial
// shift-and-add multipliers, one delta_time bit per cycle, and the restoring
// divider for the life fraction, whose quotient bits feed the fade multipliers
// one bit per cycle.
// Stall: the result sits in an output register; the next item is taken
// meanwhile and waits in its last step until that register frees up.
// Reset (synchronous): kills the particle, clears position, velocity and life,
// and restores the config registers to their defaults.
module particle_lifetime_update #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // delta_time[15:0], force_x, force_y, force_z, life_span[23:0],
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    input  logic [plu_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, scale[15:0], red, green, blue, opacity
    output logic [plu_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // alive
    output logic                          m_axis_tuser,
    input  logic                          i_cfg_we,
    input  logic [plu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [plu_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CW     = plu_pkg::COORD_W;
    localparam int DW     = plu_pkg::DT_W;
    localparam int LW     = plu_pkg::LIFE_W;
    localparam int MUL_W  = CW + DW;
    localparam int SUM_W  = MUL_W + 1;
    localparam int T_W    = FRACTION_BITS + 1;
    localparam int ACC_W  = plu_pkg::LERP_W + T_W;
    localparam int STEPS  = (T_W > DW) ? T_W : DW;
    localparam int CNT_W  = $clog2(STEPS);

    localparam int OFF_DT   = 0;
    localparam int OFF_FRC  = OFF_DT + DW;
    localparam int OFF_LIFE = OFF_FRC + 3 * CW;
    localparam int OFF_POS  = OFF_LIFE + LW;
    localparam int OFF_VEL  = OFF_POS + 3 * CW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic signed [SUM_W-1:0] C_MAX =
        {{(SUM_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] C_MIN =
        {{(SUM_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

    // Saturating add of a scaled product onto a coordinate
    function automatic plu_pkg::t_coord sat_add(plu_pkg::t_coord base,
                                                logic signed [MUL_W-1:0] prod);
        logic signed [MUL_W-1:0] shifted;
        logic signed [SUM_W-1:0] sum;
        shifted = prod >>> FRACTION_BITS;
        sum = $signed({shifted[MUL_W-1], shifted})
            + $signed({{(SUM_W-CW){base[CW-1]}}, base});
        if (sum > C_MAX) begin
            sum = C_MAX;
        end else if (sum < C_MIN) begin
            sum = C_MIN;
        end
        return sum[CW-1:0];
    endfunction

    // Control and state registers
    logic [1:0]                 r_state;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_live;
    logic                       r_is_tick;
    plu_pkg::t_life             r_rem;
    plu_pkg::t_life             r_tot;
    plu_pkg::t_coord            r_pos [3];
    plu_pkg::t_coord            r_vel [3];
    logic                       r_out_valid;

    logic [plu_pkg::SCALE_W-1:0]  r_cfg_init_scale;
    logic [plu_pkg::SCALE_W-1:0]  r_cfg_final_scale;
    logic [3*plu_pkg::CHAN_W-1:0] r_cfg_init_color;
    logic [3*plu_pkg::CHAN_W-1:0] r_cfg_final_color;
    logic [plu_pkg::CHAN_W-1:0]   r_cfg_init_alpha;
    logic [plu_pkg::CHAN_W-1:0]   r_cfg_final_alpha;

    // Datapath registers
    logic [DW-1:0]              r_dt;
    plu_pkg::t_coord            r_frc [3];
    logic signed [MUL_W-1:0]    r_mp [3];
    logic signed [MUL_W-1:0]    r_mv [3];
    logic                       r_t_one;
    logic                       r_div_en;
    plu_pkg::t_life             r_div_rem;
    logic signed [ACC_W-1:0]    r_lacc [plu_pkg::LANES];
    logic                       r_out_alive;
    logic [plu_pkg::M_TDATA_W-1:0] r_out_data;

    // Combinational nets
    logic                       w_accept;
    logic                       w_load;
    logic                       w_op;
    logic [DW-1:0]              w_in_dt;
    plu_pkg::t_life             w_in_life;
    plu_pkg::t_coord            w_in_frc [3];
    plu_pkg::t_coord            w_in_pos [3];
    plu_pkg::t_coord            w_in_vel [3];
    plu_pkg::t_life             w_rem_tick;
    plu_pkg::t_life             w_new_rem;
    plu_pkg::t_life             w_new_tot;
    logic                       w_new_live;
    logic                       w_new_t_one;
    logic                       w_mul_en;
    logic                       w_div_step;
    logic                       w_lerp_en;
    logic [LW:0]                w_div_sh;
    logic                       w_div_ge;
    plu_pkg::t_life             w_div_nxt;
    logic                       w_tbit;
    plu_pkg::t_coord            w_pos_nxt [3];
    plu_pkg::t_coord            w_vel_nxt [3];
    plu_pkg::t_coord            w_pos_res [3];
    logic [plu_pkg::SCALE_W-1:0] w_la [plu_pkg::LANES];
    logic [plu_pkg::SCALE_W-1:0] w_lb [plu_pkg::LANES];
    logic signed [plu_pkg::LERP_W-1:0] w_ld [plu_pkg::LANES];
    logic signed [ACC_W-1:0]    w_lsum [plu_pkg::LANES];
    logic [plu_pkg::SCALE_W-1:0] w_lres [plu_pkg::LANES];
    logic [plu_pkg::M_TDATA_W-1:0] w_out_data;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == ST_DONE) && (!r_out_valid || m_axis_tready);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_alive;

    // Unpack the input transfer
    always_comb begin
        w_op      = s_axis_tuser;
        w_in_dt   = s_axis_tdata[OFF_DT +: DW];
        w_in_life = s_axis_tdata[OFF_LIFE +: LW];
        for (int i = 0; i < 3; i++) begin
            w_in_frc[i] = s_axis_tdata[OFF_FRC + i*CW +: CW];
            w_in_pos[i] = s_axis_tdata[OFF_POS + i*CW +: CW];
            w_in_vel[i] = s_axis_tdata[OFF_VEL + i*CW +: CW];
        end
    end

    // Life bookkeeping at transfer time
    always_comb begin
        w_rem_tick  = (r_rem > LW'(w_in_dt)) ? (r_rem - LW'(w_in_dt)) : '0;
        w_new_rem   = (w_op == plu_pkg::OP_SPAWN) ? w_in_life : w_rem_tick;
        w_new_tot   = (w_op == plu_pkg::OP_SPAWN) ? w_in_life : r_tot;
        w_new_live  = (w_op == plu_pkg::OP_SPAWN) || (w_rem_tick != '0);
        w_new_t_one = (w_new_tot == '0) || (w_new_rem == '0);
    end

    // Step enables for the serial units
    assign w_mul_en   = (r_cnt <= CNT_W'(DW - 1));
    assign w_lerp_en  = (r_cnt <= CNT_W'(T_W - 1));
    assign w_div_step = (r_cnt != '0) && (r_cnt <= CNT_W'(FRACTION_BITS));

    // Restoring divider, one quotient bit per cycle
    always_comb begin
        w_div_sh  = {r_div_rem, 1'b0};
        w_div_ge  = (w_div_sh >= {1'b0, r_tot});
        w_div_nxt = w_div_ge ? LW'(w_div_sh - {1'b0, r_tot}) : w_div_sh[LW-1:0];
        w_tbit    = (r_cnt == '0) ? r_t_one : (r_div_en && w_div_ge);
    end

    // Fade endpoints and differences
    always_comb begin
        w_la[plu_pkg::LN_SCALE] = r_cfg_init_scale;
        w_lb[plu_pkg::LN_SCALE] = r_cfg_final_scale;
        w_la[plu_pkg::LN_RED]   = {8'd0, r_cfg_init_color[23:16]};
        w_lb[plu_pkg::LN_RED]   = {8'd0, r_cfg_final_color[23:16]};
        w_la[plu_pkg::LN_GREEN] = {8'd0, r_cfg_init_color[15:8]};
        w_lb[plu_pkg::LN_GREEN] = {8'd0, r_cfg_final_color[15:8]};
        w_la[plu_pkg::LN_BLUE]  = {8'd0, r_cfg_init_color[7:0]};
        w_lb[plu_pkg::LN_BLUE]  = {8'd0, r_cfg_final_color[7:0]};
        w_la[plu_pkg::LN_ALPHA] = {8'd0, r_cfg_init_alpha};
        w_lb[plu_pkg::LN_ALPHA] = {8'd0, r_cfg_final_alpha};
        for (int j = 0; j < plu_pkg::LANES; j++) begin
            w_ld[j]   = $signed({1'b0, w_lb[j]}) - $signed({1'b0, w_la[j]});
            w_lsum[j] = $signed({{(ACC_W-plu_pkg::SCALE_W){1'b0}}, w_la[j]})
                      + (r_lacc[j] >>> FRACTION_BITS);
            w_lres[j] = w_lsum[j][plu_pkg::SCALE_W-1:0];
        end
    end

    // Euler step results
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pos_nxt[i] = sat_add(r_pos[i], r_mp[i]);
            w_vel_nxt[i] = sat_add(r_vel[i], r_mv[i]);
            w_pos_res[i] = r_is_tick ? w_pos_nxt[i] : r_pos[i];
        end
    end

    // Result packing, zero when dead
    always_comb begin
        w_out_data = {w_lres[plu_pkg::LN_ALPHA][plu_pkg::CHAN_W-1:0],
                      w_lres[plu_pkg::LN_BLUE][plu_pkg::CHAN_W-1:0],
                      w_lres[plu_pkg::LN_GREEN][plu_pkg::CHAN_W-1:0],
                      w_lres[plu_pkg::LN_RED][plu_pkg::CHAN_W-1:0],
                      w_lres[plu_pkg::LN_SCALE],
                      w_pos_res[2], w_pos_res[1], w_pos_res[0]};
        if (!r_live) begin
            w_out_data = '0;
        end
    end

    // Sequencer, particle state and config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_cnt             <= '0;
            r_live            <= 1'b0;
            r_is_tick         <= 1'b0;
            r_rem             <= '0;
            r_tot             <= '0;
            r_out_valid       <= 1'b0;
            r_cfg_init_scale  <= plu_pkg::RST_INIT_SCALE;
            r_cfg_final_scale <= plu_pkg::RST_FINAL_SCALE;
            r_cfg_init_color  <= plu_pkg::RST_INIT_COLOR;
            r_cfg_final_color <= plu_pkg::RST_FINAL_COLOR;
            r_cfg_init_alpha  <= plu_pkg::RST_INIT_ALPHA;
            r_cfg_final_alpha <= plu_pkg::RST_FINAL_ALPHA;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            // config writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    plu_pkg::REG_INIT_SCALE:  r_cfg_init_scale  <= i_cfg_data[15:0];
                    plu_pkg::REG_FINAL_SCALE: r_cfg_final_scale <= i_cfg_data[15:0];
                    plu_pkg::REG_INIT_COLOR:  r_cfg_init_color  <= i_cfg_data;
                    plu_pkg::REG_FINAL_COLOR: r_cfg_final_color <= i_cfg_data;
                    plu_pkg::REG_INIT_ALPHA:  r_cfg_init_alpha  <= i_cfg_data[7:0];
                    plu_pkg::REG_FINAL_ALPHA: r_cfg_final_alpha <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            // output register fills with a finished item or drains on transfer
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_rem     <= w_new_rem;
                        r_tot     <= w_new_tot;
                        r_live    <= w_new_live;
                        r_is_tick <= (w_op == plu_pkg::OP_TICK);
                        r_cnt     <= '0;
                        r_state   <= ST_CALC;
                        if (w_op == plu_pkg::OP_SPAWN) begin
                            for (int i = 0; i < 3; i++) begin
                                r_pos[i] <= w_in_pos[i];
                                r_vel[i] <= w_in_vel[i];
                            end
                        end
                    end
                end
                ST_CALC: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                        if (r_is_tick && r_live) begin
                            for (int i = 0; i < 3; i++) begin
                                r_pos[i] <= w_pos_nxt[i];
                                r_vel[i] <= w_vel_nxt[i];
                            end
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Serial multipliers, divider and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt      <= w_in_dt;
            r_t_one   <= w_new_t_one;
            r_div_en  <= !w_new_t_one && (w_new_rem < w_new_tot);
            r_div_rem <= w_new_tot - w_new_rem;
            for (int i = 0; i < 3; i++) begin
                r_frc[i] <= w_in_frc[i];
                r_mp[i]  <= '0;
                r_mv[i]  <= '0;
            end
            for (int j = 0; j < plu_pkg::LANES; j++) begin
                r_lacc[j] <= '0;
            end
        end else if (r_state == ST_CALC) begin
            // shift-and-add over delta_time, MSB first
            if (w_mul_en) begin
                r_dt <= {r_dt[DW-2:0], 1'b0};
                for (int i = 0; i < 3; i++) begin
                    r_mp[i] <= (r_mp[i] <<< 1)
                             + (r_dt[DW-1] ? $signed({{(MUL_W-CW){r_vel[i][CW-1]}}, r_vel[i]})
                                           : $signed(MUL_W'(0)));
                    r_mv[i] <= (r_mv[i] <<< 1)
                             + (r_dt[DW-1] ? $signed({{(MUL_W-CW){r_frc[i][CW-1]}}, r_frc[i]})
                                           : $signed(MUL_W'(0)));
                end
            end
            if (w_div_step) begin
                r_div_rem <= w_div_nxt;
            end
            // fade lanes take the life fraction one bit per cycle, MSB first
            if (w_lerp_en) begin
                for (int j = 0; j < plu_pkg::LANES; j++) begin
                    r_lacc[j] <= (r_lacc[j] <<< 1)
                               + (w_tbit ? $signed({{(ACC_W-plu_pkg::LERP_W){w_ld[j][plu_pkg::LERP_W-1]}},
                                                    w_ld[j]})
                                         : $signed(ACC_W'(0)));
                end
            end
        end
        if (w_load) begin
            r_out_alive <= r_live;
            r_out_data  <= w_out_data;
        end
    end

endmodule

// ===== hw/rtl/plu_checker.sv =====
`timescale 1ns / 1ps

module plu_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [plu_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);

    // reset leaves the output empty and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_axis_tvalid && s_axis_tready))
        else $error("block not idle after reset");

    // one item at a time: the input closes right after a transfer
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still open after a transfer");

    // a dead particle reports all fields zero
    a_dead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("dead result carries nonzero fields");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind particle_lifetime_update plu_checker u_plu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_particle_lifetime_update.sv =====
`timescale 1ns / 1ps

module tb_particle_lifetime_update;

    localparam int LIFE_W = plu_pkg::LIFE_W;
    localparam int DT_W = plu_pkg::DT_W;
    localparam int SCALE_W = plu_pkg::SCALE_W;
    localparam int CHAN_W = plu_pkg::CHAN_W;
    localparam int CFG_W = plu_pkg::CFG_W;
    localparam int CFG_IDX_W = plu_pkg::CFG_IDX_W;

    localparam int FRAC = 16;
    localparam longint FRAC_ONE = longint'(1) << FRAC;
    localparam int SETTLE_CYCLES = 25;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 850;
    localparam int REG_PHASES = 5;
    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [LIFE_W-1:0] LIFE_MAX = 24'hFF_FFFF;
    localparam logic [DT_W-1:0] DT_MAX = 16'hFFFF;
    // indexes past the last register, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(7);

    // one input transfer: {tuser, tdata}
    typedef struct packed {
        logic                    op;
        logic [2:0][31:0]        vel;
        logic [2:0][31:0]        pos;
        logic [LIFE_W-1:0]       life;
        logic [2:0][31:0]        frc;
        logic [DT_W-1:0]         dt;
    } t_particle_item;

    // one output transfer: {tuser, tdata}
    typedef struct packed {
        logic                    alive;
        logic [CHAN_W-1:0]       opacity;
        logic [CHAN_W-1:0]       blue;
        logic [CHAN_W-1:0]       green;
        logic [CHAN_W-1:0]       red;
        logic [SCALE_W-1:0]      scale;
        logic [2:0][31:0]        pos;
    } t_particle_view;

    typedef enum int {RX_STREAM, RX_JITTER, RX_LONG_HOLD, RX_HALF_RATE} t_rx_mode;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [plu_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                   s_axis_tuser = plu_pkg::OP_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [plu_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_W-1:0]       i_cfg_data = '0;

    // shadow copy of the fade endpoints
    logic [SCALE_W-1:0]     fade_init_scale = plu_pkg::RST_INIT_SCALE;
    logic [SCALE_W-1:0]     fade_final_scale = plu_pkg::RST_FINAL_SCALE;
    logic [3*CHAN_W-1:0]    fade_init_color = plu_pkg::RST_INIT_COLOR;
    logic [3*CHAN_W-1:0]    fade_final_color = plu_pkg::RST_FINAL_COLOR;
    logic [CHAN_W-1:0]      fade_init_alpha = plu_pkg::RST_INIT_ALPHA;
    logic [CHAN_W-1:0]      fade_final_alpha = plu_pkg::RST_FINAL_ALPHA;

    // shadow copy of the particle
    logic [LIFE_W-1:0]      life_left = '0;
    logic [LIFE_W-1:0]      life_total = '0;
    logic                   particle_live = 1'b0;
    longint                 cur_pos [3] = '{0, 0, 0};
    longint                 cur_vel [3] = '{0, 0, 0};

    t_particle_view         pending_views [$];
    int                     mismatches = 0;
    int                     items_sent = 0;
    int                     spawns_sent = 0;
    int                     views_checked = 0;
    int                     alive_views = 0;
    int                     reg_settings = 1;
    int                     burst_left = 0;
    int                     idle_cycles = 0;
    int                     rx_cycles = 0;
    int                     rx_hold = 0;
    t_rx_mode               rx_mode = RX_STREAM;

    particle_lifetime_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // a + floor((b - a) * t), t in Q.FRAC
    function automatic longint fade(longint a, longint b, longint t);
        return a + (((b - a) * t) >>> FRAC);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // age/move the shadow particle by one item and return what it should show
    function automatic t_particle_view advance_particle(t_particle_item it);
        t_particle_view v;
        longint t;
        longint dp;
        longint dv;
        v = '0;
        if (it.op == plu_pkg::OP_SPAWN) begin
            life_total = it.life;
            life_left = it.life;
            for (int i = 0; i < 3; i++) begin
                cur_pos[i] = longint'($signed(it.pos[i]));
                cur_vel[i] = longint'($signed(it.vel[i]));
            end
            particle_live = 1'b1;
        end else begin
            life_left = (life_left > it.dt) ? life_left - it.dt : '0;
            particle_live = (life_left != 0);
            if (particle_live) begin
                for (int i = 0; i < 3; i++) begin
                    // position uses the old velocity
                    dp = (cur_vel[i] * longint'(it.dt)) >>> FRAC;
                    dv = (longint'($signed(it.frc[i])) * longint'(it.dt)) >>> FRAC;
                    cur_pos[i] = sat32(cur_pos[i] + dp);
                    cur_vel[i] = sat32(cur_vel[i] + dv);
                end
            end
        end
        if (!particle_live) return v;

        if (life_total == 0 || life_left == 0) t = FRAC_ONE;
        else if (life_left >= life_total) t = 0;
        else t = (longint'(life_total - life_left) << FRAC) / longint'(life_total);

        v.alive = 1'b1;
        for (int i = 0; i < 3; i++) v.pos[i] = cur_pos[i][31:0];
        v.scale = SCALE_W'(fade(fade_init_scale, fade_final_scale, t));
        v.red = CHAN_W'(fade(fade_init_color[23:16], fade_final_color[23:16], t));
        v.green = CHAN_W'(fade(fade_init_color[15:8], fade_final_color[15:8], t));
        v.blue = CHAN_W'(fade(fade_init_color[7:0], fade_final_color[7:0], t));
        v.opacity = CHAN_W'(fade(fade_init_alpha, fade_final_alpha, t));
        return v;
    endfunction

    // mix of saturation extremes, full-range and small signed values
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3: return $urandom;
            default: return 32'($signed($urandom_range(0, 4194303)) - 32'sd2097152);
        endcase
    endfunction

    function automatic logic [LIFE_W-1:0] pick_life();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return LIFE_MAX;
            2, 3, 4, 5: return LIFE_W'($urandom_range(1, 65535));
            6, 7, 8: return LIFE_W'($urandom_range(1, 1 << 20));
            default: return LIFE_W'($urandom);
        endcase
    endfunction

    function automatic t_particle_item random_item();
        t_particle_item it;
        it.op = 1'($urandom_range(0, 1));
        it.dt = DT_W'($urandom);
        it.life = pick_life();
        for (int i = 0; i < 3; i++) begin
            it.frc[i] = pick_coord();
            it.pos[i] = pick_coord();
            it.vel[i] = pick_coord();
        end
        return it;
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg_value(int width);
        logic [CFG_W-1:0] all_ones;
        all_ones = (CFG_W'(1) << width) - CFG_W'(1);
        case ($urandom_range(0, 7))
            0: return '0;
            1: return all_ones;
            default: return CFG_W'($urandom) & all_ones;
        endcase
    endfunction

    // one transfer on the input stream; valid stays up inside a burst
    task automatic send_item(t_particle_item it);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tuser = it.op;
        s_axis_tdata = {it.vel, it.pos, it.life, it.frc, it.dt};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_views.push_back(advance_particle(it));
        items_sent++;
        if (it.op == plu_pkg::OP_SPAWN) spawns_sent++;
    endtask

    // drop valid and let every pending result come out
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        burst_left = 0;
        while (pending_views.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            plu_pkg::REG_INIT_SCALE:  fade_init_scale = value[SCALE_W-1:0];
            plu_pkg::REG_FINAL_SCALE: fade_final_scale = value[SCALE_W-1:0];
            plu_pkg::REG_INIT_COLOR:  fade_init_color = value[3*CHAN_W-1:0];
            plu_pkg::REG_FINAL_COLOR: fade_final_color = value[3*CHAN_W-1:0];
            plu_pkg::REG_INIT_ALPHA:  fade_init_alpha = value[CHAN_W-1:0];
            plu_pkg::REG_FINAL_ALPHA: fade_final_alpha = value[CHAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_all_regs(logic [CFG_W-1:0] s0, logic [CFG_W-1:0] s1,
                                  logic [CFG_W-1:0] c0, logic [CFG_W-1:0] c1,
                                  logic [CFG_W-1:0] a0, logic [CFG_W-1:0] a1);
        wait_idle();
        write_reg(plu_pkg::REG_INIT_SCALE, s0);
        write_reg(plu_pkg::REG_FINAL_SCALE, s1);
        write_reg(plu_pkg::REG_INIT_COLOR, c0);
        write_reg(plu_pkg::REG_FINAL_COLOR, c1);
        write_reg(plu_pkg::REG_INIT_ALPHA, a0);
        write_reg(plu_pkg::REG_FINAL_ALPHA, a1);
        reg_settings++;
    endtask

    // ticks on a dead particle after reset, with default endpoints
    task automatic test_dead_particle();
        t_particle_item it;
        it = random_item();
        it.op = plu_pkg::OP_TICK;
        it.dt = DT_MAX;
        send_item(it);
        it = random_item();
        it.op = plu_pkg::OP_TICK;
        it.dt = '0;
        send_item(it);
    endtask

    // field extremes, saturation, zero life, exact expiry, respawn
    task automatic test_spawn_extremes();
        t_particle_item it;
        // zero life: alive with final endpoints, next tick kills it
        it = random_item();
        it.op = plu_pkg::OP_SPAWN;
        it.life = '0;
        it.pos = {32'h0, COORD_MIN, COORD_MAX};
        send_item(it);
        it = random_item();
        it.op = plu_pkg::OP_TICK;
        it.dt = '0;
        send_item(it);

        // longest life, saturating motion in both directions
        it = random_item();
        it.op = plu_pkg::OP_SPAWN;
        it.life = LIFE_MAX;
        it.pos = {32'h0, COORD_MIN, COORD_MAX};
        it.vel = {32'h1, COORD_MIN, COORD_MAX};
        send_item(it);
        it.op = plu_pkg::OP_TICK;
        it.dt = '0;
        send_item(it);
        it.dt = DT_MAX;
        it.frc = {32'h0, COORD_MIN, COORD_MAX};
        repeat (3) send_item(it);
        it.frc = {COORD_MIN, COORD_MAX, COORD_MIN};
        send_item(it);

        // expires exactly on the tick
        it = random_item();
        it.op = plu_pkg::OP_SPAWN;
        it.life = LIFE_W'(1);
        send_item(it);
        it.op = plu_pkg::OP_TICK;
        it.dt = DT_W'(1);
        send_item(it);

        // partial life, then a tick that ages it part of the way
        it = random_item();
        it.op = plu_pkg::OP_SPAWN;
        it.life = LIFE_W'(100);
        it.vel = {32'hFFFF_FFFF, 32'hFFFF_0001, 32'hFFFF_FFFD};
        send_item(it);
        it.op = plu_pkg::OP_TICK;
        it.dt = DT_W'(40);
        it.frc = {32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_8001};
        send_item(it);
        // respawn while alive
        it = random_item();
        it.op = plu_pkg::OP_SPAWN;
        it.life = LIFE_W'(3000);
        send_item(it);
        it.op = plu_pkg::OP_TICK;
        it.dt = DT_W'(7000);
        send_item(it);
    endtask

    // endpoint extremes, rising and falling fades, spare indexes
    task automatic test_fade_endpoints();
        t_particle_item it;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_all_regs('0, '0, '0, '0, '0, '0);
                1: write_all_regs(24'hFFFF, 24'hFFFF, 24'hFFFFFF, 24'hFFFFFF,
                                  24'hFF, 24'hFF);
                2: write_all_regs(24'hFFFF, '0, 24'hFFFFFF, 24'h00FF00, 24'hFF, '0);
                default: begin
                    write_all_regs('0, 24'hFFFF, 24'h00FF00, 24'hFFFFFF, '0, 24'hFF);
                    write_reg(REG_SPARE_LO, 24'h123456);
                    write_reg(REG_SPARE_HI, 24'hFFFFFF);
                end
            endcase
            it = random_item();
            it.op = plu_pkg::OP_SPAWN;
            it.life = LIFE_W'(1000);
            send_item(it);
            it.op = plu_pkg::OP_TICK;
            it.dt = DT_W'(333);
            repeat (2) send_item(it);
        end
    endtask

    // spawn-and-age sequences with random content, plus stray items
    task automatic test_random_lifecycles();
        t_particle_item it;
        int chunk_end;
        int ticks;
        int dt_base;
        int dt_now;
        for (int phase = 0; phase < REG_PHASES; phase++) begin
            write_all_regs(pick_reg_value(SCALE_W), pick_reg_value(SCALE_W),
                           pick_reg_value(3 * CHAN_W), pick_reg_value(3 * CHAN_W),
                           pick_reg_value(CHAN_W), pick_reg_value(CHAN_W));
            chunk_end = items_sent + RANDOM_ITEMS / REG_PHASES;
            while (items_sent < chunk_end) begin
                it = random_item();
                if ($urandom_range(0, 9) < 8) begin
                    it.op = plu_pkg::OP_SPAWN;
                    send_item(it);
                    dt_base = int'(it.life) / $urandom_range(1, 30);
                    if (dt_base > 65535) dt_base = 65535;
                    if (dt_base < 1) dt_base = 1;
                    ticks = 0;
                    while (particle_live && ticks < 40) begin
                        it = random_item();
                        it.op = plu_pkg::OP_TICK;
                        dt_now = dt_base + $urandom_range(0, dt_base / 4);
                        it.dt = (dt_now > 65535) ? DT_MAX : DT_W'(dt_now);
                        send_item(it);
                        ticks++;
                    end
                end else begin
                    send_item(it);
                end
            end
        end
    endtask

    // receiver stalls, with a pattern that is redrawn at random during the run
    always @(negedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 300 == 0) rx_mode = t_rx_mode'($urandom_range(0, 3));
        if (rx_hold > 0) begin
            m_axis_tready = 1'b0;
            rx_hold--;
        end else begin
            m_axis_tready = 1'b1;
            case (rx_mode)
                RX_JITTER:    if ($urandom_range(0, 1) == 0) rx_hold = $urandom_range(1, 3);
                RX_LONG_HOLD: if ($urandom_range(0, 7) == 0) rx_hold = $urandom_range(5, 40);
                RX_HALF_RATE: rx_hold = 1;
                default: ;
            endcase
        end
    end

    task automatic compare_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // compare each output transfer with the oldest expectation
    always @(posedge i_clk) begin : check_views
        t_particle_view want;
        t_particle_view got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tuser, m_axis_tdata};
            if (pending_views.size() == 0) begin
                $error("output transfer with nothing expected: 0x%0h", got);
                mismatches++;
            end else begin
                want = pending_views.pop_front();
                views_checked++;
                if (want.alive) alive_views++;
                compare_field("alive", want.alive, got.alive);
                compare_field("out_pos_x", want.pos[0], got.pos[0]);
                compare_field("out_pos_y", want.pos[1], got.pos[1]);
                compare_field("out_pos_z", want.pos[2], got.pos[2]);
                compare_field("scale", want.scale, got.scale);
                compare_field("red", want.red, got.red);
                compare_field("green", want.green, got.green);
                compare_field("blue", want.blue, got.blue);
                compare_field("opacity", want.opacity, got.opacity);
            end
        end
    end

    // watchdog: cycles in a row with no transfer on either stream
    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: %0d cycles without a transfer", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_dead_particle();
        test_spawn_extremes();
        test_fade_endpoints();
        test_random_lifecycles();

        wait_idle();
        $display("%0d items in (%0d spawns), %0d results checked, %0d alive",
                 items_sent, spawns_sent, views_checked, alive_views);
        $display("%0d endpoint settings, %0d mismatches", reg_settings, mismatches);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== particle_lifetime_update.f =====
hw/rtl/plu_pkg.sv
hw/rtl/particle_lifetime_update.sv
hw/rtl/plu_checker.sv
tb/tb_particle_lifetime_update.sv
